>>> hdl/sdbe_pkg.sv
package sdbe_pkg;

  localparam int SampleWidth = 24;
  localparam int CoefWidth   = 24;
  localparam int WordBits    = 48;
  localparam int FracBits    = WordBits - SampleWidth - 8;
  localparam int CfgIdxWidth = 3;
  localparam int CfgDataWidth = 2 * CoefWidth;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] RegMode   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegGain   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegSide   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegFirst  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegSecond = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegNum    = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegDen    = 3'd6;

  localparam logic OpProcess = 1'b0;
  localparam logic OpClear   = 1'b1;

  typedef logic signed [WordBits-1:0] word_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,     // load input words
    DP_BQ_MAC,   // biquad multiply-accumulate, term in step
    DP_BQ_DONE,  // store y and form outputs
    DP_SP_START, // start splitter k
    DP_SP_STAGE, // one pole stage (lower or upper) of splitter k
    DP_SP_END,   // finish splitter k
    DP_GAIN,     // bass gain on xl/xr low band
    DP_MIX,      // mix term for channel
    DP_OUT,      // latch outputs
    DP_CLEAR     // clear state entry
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] k;     // splitter or channel
    logic [1:0] stage;
    logic       upper;
    logic [2:0] term;
    logic [4:0] addr;
  } dp_cmd_t;

  // saturate a wide sum back to one word
  function automatic word_t sat_word(input logic signed [WordBits+2:0] v);
    if (v[WordBits+2:WordBits-1] == '0 || v[WordBits+2:WordBits-1] == '1)
      return v[WordBits-1:0];
    return v[WordBits+2] ? {1'b1, {(WordBits-1){1'b0}}} : {1'b0, {(WordBits-1){1'b1}}};
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    return sat_word((WordBits+3)'(a) + (WordBits+3)'(b));
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    return sat_word((WordBits+3)'(a) - (WordBits+3)'(b));
  endfunction

endpackage

>>> hdl/stereo_dynamic_bass_enhancer.sv
// Each request runs step by step through one shared two-stage multiplier and the pole RAM read:
// the biquad terms in low-pass mode, or the splitters, bass gain and mix in band-split mode.
// Throughput: one request at a time; the next is taken once the result is handed to the output
// stage and the controller is idle again. A clear request gives no result.
// Reset (rst, synchronous) restores register defaults and sweeps all filter state to zero;
// no request is taken until the sweep ends.
import sdbe_pkg::*;
module stereo_dynamic_bass_enhancer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic signed [SampleWidth-1:0] left_in,
  input  logic signed [SampleWidth-1:0] right_in,
  input  logic                          block_end_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SampleWidth-1:0] left_out,
  output logic signed [SampleWidth-1:0] right_out,
  output logic                          block_end_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CfgIdxWidth-1:0]        cfg_index,
  input  logic [CfgDataWidth-1:0]       cfg_data
);
  logic                   biquad_mode;
  logic [CoefWidth-1:0]   bass_gain;
  logic [CfgDataWidth-1:0] side_gains, first_split_angles, second_split_angles;
  logic [CfgDataWidth-1:0] lowpass_numerator, lowpass_denominator;
  logic signed [SampleWidth-1:0] l_hold, r_hold, left_res, right_res;
  logic   be_hold, busy, in_acc, cfg_acc, cfg_clear, out_free;
  dp_cmd_t cmd;

  // hold requests off while a register write is offered
  assign in_stall  = busy || cfg_valid;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = !busy;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_clear = cfg_acc && (cfg_index == RegNum || cfg_index == RegDen);
  assign out_free  = !out_valid || !out_stall;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      biquad_mode <= 1'b1;
      bass_gain <= '0; side_gains <= '0; first_split_angles <= '0;
      second_split_angles <= '0; lowpass_numerator <= '0; lowpass_denominator <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        RegMode:   biquad_mode <= cfg_data[0];
        RegGain:   bass_gain <= cfg_data[CoefWidth-1:0];
        RegSide:   side_gains <= cfg_data;
        RegFirst:  first_split_angles <= cfg_data;
        RegSecond: second_split_angles <= cfg_data;
        RegNum:    lowpass_numerator <= cfg_data;
        RegDen:    lowpass_denominator <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold request payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      l_hold  <= left_in;
      r_hold  <= right_in;
      be_hold <= block_end_in;
    end
  end

  sdbe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(in_acc && opcode == OpProcess),
    .start_clear(in_acc && opcode == OpClear), .cfg_clear(cfg_clear),
    .mode(biquad_mode), .out_free(out_free), .busy(busy), .cmd(cmd)
  );

  sdbe_datapath u_dp (
    .clk(clk), .cmd(cmd), .left_in(l_hold), .right_in(r_hold),
    .bass_gain(bass_gain), .side_gains(side_gains),
    .first_split_angles(first_split_angles), .second_split_angles(second_split_angles),
    .lowpass_numerator(lowpass_numerator), .lowpass_denominator(lowpass_denominator),
    .left_res(left_res), .right_res(right_res)
  );

  // output register: after DP_OUT, results pass through the datapath result register and then this one
  logic out_load;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_load  <= 1'b0;
    end else begin
      out_load <= (cmd.op == DP_OUT);
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_out      <= left_res;
      right_out     <= right_res;
      block_end_out <= be_hold;
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall) else $error("input taken while busy");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !out_valid || $past(!out_stall)) else $error("output overwritten");
endmodule

>>> hdl/sdbe_ram.sv
module sdbe_ram #(
  parameter int Width = 48,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/sdbe_mul.sv
import sdbe_pkg::*;
// Rounded multiply with registered partial products and product: word by coefficient, split in 24-bit halves.
module sdbe_mul (
  input  logic                       clk,
  input  word_t                      a,
  input  logic signed [CoefWidth+1:0] c,
  input  logic [4:0]                 sh,
  output word_t                      p
);
  logic signed [WordBits-1:0]  a_s;
  logic signed [24:0]          al;
  logic signed [23:0]          ah;
  logic signed [51:0]          hi;
  logic signed [51:0]          lo;
  logic [4:0]                  sh_q;
  logic signed [WordBits+23:0] full;
  logic signed [WordBits+23:0] rnd;
  logic [24:0]                 rnd_top;

  assign a_s = a;
  assign ah  = a_s[WordBits-1:24];
  assign al  = {1'b0, a_s[23:0]};

  // stage 1: partial products
  always_ff @(posedge clk) begin
    hi   <= 52'(ah * c);
    lo   <= 52'(al * c);
    sh_q <= sh;
  end

  // stage 2: combine, round half up, shift, saturate
  always_comb begin
    full = ((WordBits+24)'(hi) <<< 24) + (WordBits+24)'(lo)
         + ((WordBits+24)'(1) <<< (sh_q - 5'd1));
    rnd  = full >>> sh_q;
  end

  assign rnd_top = rnd[WordBits+23:WordBits-1];

  always_ff @(posedge clk) begin
    if (rnd_top == '0 || rnd_top == '1) p <= rnd[WordBits-1:0];
    else if (rnd[WordBits+23]) p <= {1'b1, {(WordBits-1){1'b0}}};
    else p <= {1'b0, {(WordBits-1){1'b1}}};
  end
endmodule

>>> hdl/sdbe_ctrl.sv
import sdbe_pkg::*;
module sdbe_ctrl (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    start_clear,
  input  logic    cfg_clear,
  input  logic    mode,
  input  logic    out_free,
  output logic    busy,
  output dp_cmd_t cmd
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BQ    = 4'd1;
  localparam logic [3:0] S_SPS   = 4'd2;
  localparam logic [3:0] S_SPG   = 4'd3;
  localparam logic [3:0] S_SPE   = 4'd4;
  localparam logic [3:0] S_GAIN  = 4'd5;
  localparam logic [3:0] S_MIX   = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_CLR   = 4'd8;
  localparam logic [3:0] S_BQD   = 4'd9;
  localparam logic [3:0] S_LOAD  = 4'd10;

  logic [3:0] state, state_next;
  logic [3:0] wait_cnt, wait_cnt_next;
  logic [1:0] k, k_next;
  logic [2:0] sub, sub_next;
  logic [4:0] addr, addr_next;

  // each multiply/pole step takes a fixed wait for the registered RAM and multiplier
  localparam logic [3:0] StepWait = 4'd5;

  always_comb begin
    state_next    = state;
    wait_cnt_next = wait_cnt;
    k_next        = k;
    sub_next      = sub;
    addr_next     = addr;
    cmd           = '0;
    cmd.op        = DP_NOP;
    cmd.k         = k;
    cmd.stage     = sub[2:1];
    cmd.upper     = sub[0];
    cmd.term      = sub;
    cmd.addr      = addr;
    unique case (state)
      S_IDLE: begin
        if (cfg_clear) begin
          state_next = S_CLR;
          addr_next  = '0;
        end else if (start_clear) begin
          state_next = S_CLR;
          addr_next  = '0;
        end else if (start) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.op    = DP_LOAD;
        k_next    = '0;
        sub_next  = '0;
        wait_cnt_next = '0;
        state_next = mode ? S_BQ : S_SPS;
      end
      S_BQ: begin
        cmd.op = (wait_cnt == '0) ? DP_BQ_MAC : DP_NOP;
        wait_cnt_next = wait_cnt + 4'd1;
        if (wait_cnt == StepWait) begin
          wait_cnt_next = '0;
          if (sub == 3'd3) state_next = S_BQD;
          else sub_next = sub + 3'd1;
        end
      end
      S_BQD: begin
        cmd.op     = DP_BQ_DONE;
        state_next = S_OUT;
      end
      S_SPS: begin
        cmd.op        = DP_SP_START;
        sub_next      = '0;
        wait_cnt_next = '0;
        state_next    = S_SPG;
      end
      S_SPG: begin
        cmd.op = (wait_cnt == '0) ? DP_SP_STAGE : DP_NOP;
        wait_cnt_next = wait_cnt + 4'd1;
        if (wait_cnt == StepWait) begin
          wait_cnt_next = '0;
          if (sub == 3'd7) state_next = S_SPE;
          else sub_next = sub + 3'd1;
        end
      end
      S_SPE: begin
        cmd.op = DP_SP_END;
        wait_cnt_next = '0;
        if (k == 2'd1) begin
          state_next = S_GAIN;
          sub_next   = '0;
        end else if (k == 2'd3) begin
          state_next = S_MIX;
          k_next     = '0;
          sub_next   = '0;
        end else state_next = S_SPS;
        if (k != 2'd3) k_next = k + 2'd1;
      end
      S_GAIN: begin
        cmd.op = (wait_cnt == '0) ? DP_GAIN : DP_NOP;
        cmd.k  = {1'b0, sub[0]};
        wait_cnt_next = wait_cnt + 4'd1;
        if (wait_cnt == StepWait) begin
          wait_cnt_next = '0;
          if (sub[0]) begin
            state_next = S_SPS;
            sub_next   = '0;
          end else sub_next = 3'd1;
        end
      end
      S_MIX: begin
        cmd.op = (wait_cnt == '0) ? DP_MIX : DP_NOP;
        wait_cnt_next = wait_cnt + 4'd1;
        if (wait_cnt == StepWait) begin
          wait_cnt_next = '0;
          if (sub[0]) begin
            sub_next = '0;
            if (k == 2'd1) state_next = S_OUT;
            else k_next = 2'd1;
          end else sub_next = 3'd1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.op     = DP_OUT;
          state_next = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.op    = DP_CLEAR;
        addr_next = addr + 5'd1;
        if (addr == 5'd15) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      wait_cnt <= '0;
      k        <= '0;
      sub      <= '0;
      addr     <= '0;
    end else begin
      state    <= state_next;
      wait_cnt <= wait_cnt_next;
      k        <= k_next;
      sub      <= sub_next;
      addr     <= addr_next;
    end
  end

  assign busy = (state != S_IDLE);
endmodule

>>> hdl/sdbe_datapath.sv
import sdbe_pkg::*;
module sdbe_datapath (
  input  logic                   clk,
  input  dp_cmd_t                cmd,
  input  logic signed [SampleWidth-1:0] left_in,
  input  logic signed [SampleWidth-1:0] right_in,
  input  logic [CoefWidth-1:0]   bass_gain,
  input  logic [2*CoefWidth-1:0] side_gains,
  input  logic [2*CoefWidth-1:0] first_split_angles,
  input  logic [2*CoefWidth-1:0] second_split_angles,
  input  logic [2*CoefWidth-1:0] lowpass_numerator,
  input  logic [2*CoefWidth-1:0] lowpass_denominator,
  output logic signed [SampleWidth-1:0] left_res,
  output logic signed [SampleWidth-1:0] right_res
);
  localparam logic [4:0] ShPole = 5'(CoefWidth - 1);
  localparam logic [4:0] ShQ22  = 5'(CoefWidth - 2);
  localparam logic [4:0] ShGain = 5'(CoefWidth - 5);

  word_t li, ri, bq_s;
  logic signed [WordBits+2:0] acc;
  word_t h [4];
  word_t d [12];
  word_t o0 [4];
  word_t o1 [4];
  word_t o2 [4];
  word_t sin_w [2];
  word_t px, py, lo_w, ro_w;
  word_t mul_a, mul_p;
  logic signed [CoefWidth+1:0] mul_c;
  logic [4:0] mul_sh;
  dp_cmd_t cmd_d [5];

  // pole chain storage: lower and upper chains in their own RAMs
  logic        x_we, y_we;
  logic [3:0]  pole_addr;
  word_t       x_rd, y_rd, pole_wd;

  sdbe_ram #(.Width(WordBits), .Depth(16)) u_lower (
    .clk(clk), .we(x_we), .waddr(pole_addr), .wdata(pole_wd),
    .raddr(pole_addr), .rdata(x_rd)
  );
  sdbe_ram #(.Width(WordBits), .Depth(16)) u_upper (
    .clk(clk), .we(y_we), .waddr(pole_addr), .wdata(pole_wd),
    .raddr(pole_addr), .rdata(y_rd)
  );

  sdbe_mul u_mul (.clk(clk), .a(mul_a), .c(mul_c), .sh(mul_sh), .p(mul_p));

  function automatic logic signed [CoefWidth+1:0] shalf(input logic [2*CoefWidth-1:0] r,
                                                        input logic w);
    return w ? (CoefWidth+2)'($signed(r[2*CoefWidth-1:CoefWidth]))
             : (CoefWidth+2)'($signed(r[CoefWidth-1:0]));
  endfunction

  function automatic logic signed [CoefWidth+1:0] uhalf(input logic [2*CoefWidth-1:0] r,
                                                        input logic w);
    return w ? (CoefWidth+2)'({1'b0, r[2*CoefWidth-1:CoefWidth]})
             : (CoefWidth+2)'({1'b0, r[CoefWidth-1:0]});
  endfunction

  function automatic logic signed [SampleWidth-1:0] to_out(input word_t v);
    logic signed [WordBits:0] q;
    logic signed [WordBits:0] top;
    q   = ((WordBits+1)'(v) + (WordBits+1)'(1 <<< (FracBits-1))) >>> FracBits;
    top = (WordBits+1)'((1 <<< (SampleWidth-1)) - 1);
    if (q > top) return top[SampleWidth-1:0];
    if (q < -top - 1) return {1'b1, {(SampleWidth-1){1'b0}}};
    return q[SampleWidth-1:0];
  endfunction

  // delay command so the write-back sees RAM data and product
  always_ff @(posedge clk) begin
    cmd_d[0] <= cmd;
    for (int i = 1; i < 5; i++) cmd_d[i] <= cmd_d[i-1];
  end

  dp_cmd_t wb;
  assign wb = cmd_d[3];

  // multiplier operand selection at issue time
  always_comb begin
    mul_a  = '0;
    mul_c  = '0;
    mul_sh = ShQ22;
    pole_addr = {cmd.k, cmd.stage};
    if (cmd_d[0].op == DP_SP_STAGE) pole_addr = {cmd_d[0].k, cmd_d[0].stage};
    if (cmd_d[3].op == DP_SP_STAGE) pole_addr = {cmd_d[3].k, cmd_d[3].stage};
    if (cmd.op == DP_CLEAR) pole_addr = cmd.addr[3:0];
    unique case (cmd_d[1].op)
      DP_BQ_MAC: begin
        unique case (cmd_d[1].term[1:0])
          2'd0: begin mul_a = sat_add(bq_s, h[1]); mul_c = shalf(lowpass_numerator, 1'b0); end
          2'd1: begin mul_a = h[0]; mul_c = shalf(lowpass_numerator, 1'b1); end
          2'd2: begin mul_a = h[2]; mul_c = shalf(lowpass_denominator, 1'b0); end
          default: begin mul_a = h[3]; mul_c = shalf(lowpass_denominator, 1'b1); end
        endcase
      end
      DP_SP_STAGE: begin
        mul_sh = ShPole;
        if (cmd_d[1].upper) begin
          mul_a = sat_sub(py, y_rd);
          mul_c = uhalf(cmd_d[1].k[1] ? second_split_angles : first_split_angles, 1'b1);
        end else begin
          mul_a = sat_sub(px, x_rd);
          mul_c = uhalf(cmd_d[1].k[1] ? second_split_angles : first_split_angles, 1'b0);
        end
      end
      DP_GAIN: begin
        mul_sh = ShGain;
        mul_a  = o0[cmd_d[1].k];
        mul_c  = (CoefWidth+2)'({1'b0, bass_gain});
      end
      DP_MIX: begin
        mul_a = cmd_d[1].term[0] ? o0[{1'b1, cmd_d[1].k[0]}] : o1[{1'b1, cmd_d[1].k[0]}];
        mul_c = shalf(side_gains, cmd_d[1].term[0]);
      end
      default: ;
    endcase
  end

  // pole write-back: x[i] += product, or y[i]
  word_t pole_cur;
  always_comb begin
    x_we = 1'b0;
    y_we = 1'b0;
    pole_cur = wb.upper ? y_rd : x_rd;
    pole_wd = sat_add(pole_cur, mul_p);
    if (cmd.op == DP_CLEAR) begin
      x_we = 1'b1;
      y_we = 1'b1;
      pole_wd = '0;
    end else if (wb.op == DP_SP_STAGE) begin
      x_we = !wb.upper;
      y_we = wb.upper;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        li   <= word_t'(left_in) <<< FracBits;
        ri   <= word_t'(right_in) <<< FracBits;
        bq_s <= sat_add(word_t'(left_in) <<< FracBits, word_t'(right_in) <<< FracBits);
        acc  <= '0;
      end
      DP_SP_START: begin
        unique case (cmd.k)
          2'd0: sin_w[0] <= li;
          2'd1: sin_w[0] <= ri;
          2'd2: sin_w[0] <= o2[2];
          default: sin_w[0] <= o2[3];
        endcase
        px <= (cmd.k == 2'd0) ? li : (cmd.k == 2'd1) ? ri : o2[cmd.k];
        py <= (cmd.k == 2'd0) ? li : (cmd.k == 2'd1) ? ri : o2[cmd.k];
        // shift the delay line, keep the oldest
        sin_w[1] <= d[cmd.k*3+2];
        d[cmd.k*3+2] <= d[cmd.k*3+1];
        d[cmd.k*3+1] <= d[cmd.k*3];
        d[cmd.k*3] <= (cmd.k == 2'd0) ? li : (cmd.k == 2'd1) ? ri : o2[cmd.k];
      end
      DP_SP_END: begin
        o0[cmd.k] <= px;
        o1[cmd.k] <= sat_sub(sin_w[1], py);
        o2[cmd.k] <= sat_sub(py, px);
      end
      DP_BQ_DONE: begin
        h[1] <= h[0];
        h[0] <= bq_s;
        h[3] <= h[2];
        h[2] <= sat_word(acc);
        lo_w <= sat_add(li, sat_word(acc));
        ro_w <= sat_add(ri, sat_word(acc));
      end
      DP_OUT: begin
        left_res  <= to_out(lo_w);
        right_res <= to_out(ro_w);
      end
      DP_CLEAR: begin
        if (cmd.addr == 5'd0) begin
          for (int i = 0; i < 4; i++) h[i] <= '0;
          for (int i = 0; i < 12; i++) d[i] <= '0;
        end
      end
      default: ;
    endcase

    // product arrives through the multiplier's partial-product and output registers; biquad sum kept exact until done
    if (wb.op == DP_BQ_MAC) begin
      acc <= (wb.term[1:0] == 2'd0) ? (WordBits+3)'(mul_p)
           : (wb.term[1]) ? acc - (WordBits+3)'(mul_p) : acc + (WordBits+3)'(mul_p);
    end
    if (wb.op == DP_SP_STAGE) begin
      if (wb.upper) py <= pole_wd;
      else px <= pole_wd;
    end
    if (wb.op == DP_GAIN) o2[{1'b1, wb.k[0]}] <= mul_p;
    if (wb.op == DP_MIX) begin
      if (wb.term[0]) begin
        if (wb.k[0]) ro_w <= sat_word((WordBits+3)'(o1[1]) + (WordBits+3)'(o2[3])
                           + acc + (WordBits+3)'(mul_p) + (WordBits+3)'(o2[1]));
        else lo_w <= sat_word((WordBits+3)'(o1[0]) + (WordBits+3)'(o2[2])
                           + acc + (WordBits+3)'(mul_p) + (WordBits+3)'(o2[0]));
      end else acc <= (WordBits+3)'(mul_p);
    end
  end
endmodule
